[hw/rtl/median_filter_3x3_assert.svh]
// median_filter_3x3_assert.svh: assertion macros for the median filter checker
// no dependencies; taken in by the checker file
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MF3_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("median filter check failed");

// next-cycle implication, disabled while reset is low
`define MF3_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("median filter check failed");

`endif

[hw/rtl/mf3_pkg.sv]
// mf3_pkg: constants, codes and the job type of the 3x3 median filter
// no dependencies; used by every other file of the block but the assertion header
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 1024;

    localparam int PIX_W       = 8;
    localparam int FW_W        = 7;
    localparam int FH_W        = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = FH_W;
    localparam int BAND_W      = 2;
    localparam int STORE_DEPTH = 3 * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        CMD_PUSH  = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // one unit of work handed from the front to the back
    typedef struct packed
    {
        logic              wr_en;
        logic              emit;
        logic              border;
        logic              last;
        logic [PIX_W-1:0]  pixel;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] mid_addr;
        logic [ADDR_W-1:0] up_addr;
    } job_t;

endpackage

[hw/rtl/mf3_if.sv]
// mf3_if: valid/ready channel interfaces of the median filter
// depends on mf3_pkg for field widths
`timescale 1ns / 1ps

interface mf3_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [mf3_pkg::PIX_W-1:0]   pixel_in;

    modport source (output valid, output command, output pixel_in, input ready);
    modport sink   (input valid, input command, input pixel_in, output ready);
endinterface

interface mf3_res_if;
    logic                        valid;
    logic                        ready;
    logic [mf3_pkg::PIX_W-1:0]   pixel_out;
    logic                        is_border;
    logic                        frame_last;

    modport source (output valid, output pixel_out, output is_border, output frame_last,
                    input ready);
    modport sink   (input valid, input pixel_out, input is_border, input frame_last,
                    output ready);
endinterface

interface mf3_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mf3_pkg::CFG_IDX_W-1:0]   index;
    logic [mf3_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/mf3_front.sv]
// mf3_front: accepts beats and register writes, tracks frame positions, builds jobs
// depends on mf3_pkg and mf3_if
`timescale 1ns / 1ps

module mf3_front
(
    input  logic           clk,
    input  logic           rst_n,
    mf3_pix_if.sink        pixels,
    mf3_cfg_if.sink        regs,
    input  logic           q_full,
    output logic           enq,
    output mf3_pkg::job_t  enq_job
);

    localparam logic [mf3_pkg::FW_W-1:0] W_MIN = mf3_pkg::FW_W'(3);
    localparam logic [mf3_pkg::FW_W-1:0] W_MAX = mf3_pkg::FW_W'(mf3_pkg::MAX_WIDTH);
    localparam logic [mf3_pkg::FH_W-1:0] H_MIN = mf3_pkg::FH_W'(3);
    localparam logic [mf3_pkg::FH_W-1:0] H_MAX = mf3_pkg::FH_W'(mf3_pkg::MAX_HEIGHT);

    logic [mf3_pkg::FW_W-1:0]   fw_reg;
    logic [mf3_pkg::FH_W-1:0]   fh_reg;
    logic [mf3_pkg::ROW_W-1:0]  in_row_reg;
    logic [mf3_pkg::COL_W-1:0]  in_col_reg;
    logic [mf3_pkg::BAND_W-1:0] in_band_reg;
    logic [mf3_pkg::ROW_W-1:0]  out_row_reg;
    logic [mf3_pkg::COL_W-1:0]  out_col_reg;
    logic                       complete_reg;

    logic [mf3_pkg::FW_W-1:0]   w_eff;
    logic [mf3_pkg::FW_W-1:0]   w_m1;
    logic [mf3_pkg::FH_W-1:0]   h_eff;
    logic [mf3_pkg::FH_W-1:0]   h_m1;
    logic [mf3_pkg::BAND_W-1:0] band_m1;
    logic [mf3_pkg::BAND_W-1:0] band_m2;
    logic [mf3_pkg::BAND_W-1:0] band_next;
    logic                       in_last_col;
    logic                       in_last_row;
    logic                       out_last_col;
    logic                       out_last_row;
    logic                       is_drain;
    logic                       do_push;
    logic                       do_drain;
    logic                       emit;
    logic                       out_border;
    logic                       out_last;

    function automatic logic [mf3_pkg::ADDR_W-1:0] band_addr
    (
        input logic [mf3_pkg::BAND_W-1:0] band,
        input logic [mf3_pkg::COL_W-1:0]  col
    );
        return mf3_pkg::ADDR_W'(band) * mf3_pkg::ADDR_W'(mf3_pkg::MAX_WIDTH)
               + mf3_pkg::ADDR_W'(col);
    endfunction

    assign regs.ready   = 1'b1;
    assign pixels.ready = !q_full;

    always_comb
    begin
        priority if (fw_reg < W_MIN)
            w_eff = W_MIN;
        else if (fw_reg > W_MAX)
            w_eff = W_MAX;
        else
            w_eff = fw_reg;

        priority if (fh_reg < H_MIN)
            h_eff = H_MIN;
        else if (fh_reg > H_MAX)
            h_eff = H_MAX;
        else
            h_eff = fh_reg;
    end

    assign w_m1 = w_eff - mf3_pkg::FW_W'(1);
    assign h_m1 = h_eff - mf3_pkg::FH_W'(1);

    // rows live in bands row mod 3; the two rows above the input row
    always_comb
    begin
        unique case (in_band_reg)
            2'd0:
            begin
                band_m1   = 2'd2;
                band_m2   = 2'd1;
                band_next = 2'd1;
            end
            2'd1:
            begin
                band_m1   = 2'd0;
                band_m2   = 2'd2;
                band_next = 2'd2;
            end
            default:
            begin
                band_m1   = 2'd1;
                band_m2   = 2'd0;
                band_next = 2'd0;
            end
        endcase
    end

    assign in_last_col  = (mf3_pkg::FW_W'(in_col_reg) == w_m1);
    assign in_last_row  = (in_row_reg == h_m1);
    assign out_last_col = (mf3_pkg::FW_W'(out_col_reg) == w_m1);
    assign out_last_row = (out_row_reg == h_m1);

    assign is_drain = (mf3_pkg::cmd_t'(pixels.command) == mf3_pkg::CMD_DRAIN);
    assign do_push  = !is_drain && !complete_reg;
    assign do_drain = is_drain && complete_reg;

    // a push emits once the lower-right neighbour of the next output is in
    assign emit = do_drain
                || (do_push && ((in_row_reg >= mf3_pkg::ROW_W'(2))
                || (in_row_reg == mf3_pkg::ROW_W'(1) && in_col_reg != '0)));

    assign out_border = (out_row_reg == '0) || (out_col_reg == '0)
                      || out_last_row || out_last_col;
    assign out_last   = out_last_row && out_last_col;

    assign enq = pixels.valid && pixels.ready && (do_push || do_drain);

    always_comb
    begin
        enq_job.wr_en    = do_push;
        enq_job.emit     = emit;
        enq_job.border   = out_border;
        enq_job.last     = out_last;
        enq_job.pixel    = pixels.pixel_in;
        enq_job.wr_addr  = band_addr(in_band_reg, in_col_reg);
        enq_job.mid_addr = band_addr(band_m1, in_col_reg);
        enq_job.up_addr  = band_addr(band_m2, in_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg       <= mf3_pkg::FW_W'(5);
            fh_reg       <= mf3_pkg::FH_W'(5);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_band_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            complete_reg <= 1'b0;
        end
        else if (regs.valid)
        begin
            if (regs.index == mf3_pkg::CFG_FRAME_WIDTH)
                fw_reg <= regs.data[mf3_pkg::FW_W-1:0];
            if (regs.index == mf3_pkg::CFG_FRAME_HEIGHT)
                fh_reg <= regs.data[mf3_pkg::FH_W-1:0];
            if (regs.index == mf3_pkg::CFG_FRAME_WIDTH
                || regs.index == mf3_pkg::CFG_FRAME_HEIGHT)
            begin
                in_row_reg   <= '0;
                in_col_reg   <= '0;
                in_band_reg  <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                complete_reg <= 1'b0;
            end
        end
        else if (enq)
        begin
            if (emit && out_last)
            begin
                in_row_reg   <= '0;
                in_col_reg   <= '0;
                in_band_reg  <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                complete_reg <= 1'b0;
            end
            else
            begin
                // drains keep walking the input position past the last row so the
                // back reads the right columns for the tail
                if (in_last_col)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + mf3_pkg::ROW_W'(1);
                    in_band_reg <= band_next;
                    if (do_push && in_last_row)
                        complete_reg <= 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + mf3_pkg::COL_W'(1);
                end

                if (emit)
                begin
                    if (out_last_col)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + mf3_pkg::ROW_W'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + mf3_pkg::COL_W'(1);
                    end
                end
            end
        end
    end

endmodule

[hw/rtl/mf3_queue.sv]
// mf3_queue: short job queue between the front and the back of the median filter
// depends on mf3_pkg for the job type and depth
`timescale 1ns / 1ps

module mf3_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mf3_pkg::job_t  push_job,
    output logic           full,
    output logic           valid,
    output mf3_pkg::job_t  head,
    input  logic           pop
);

    mf3_pkg::job_t                entry_reg [mf3_pkg::QUEUE_DEPTH];
    logic [mf3_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mf3_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mf3_pkg::QCNT_W-1:0]   count_reg;

    assign full  = (count_reg == mf3_pkg::QCNT_W'(mf3_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    // pointers wrap naturally since the depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + mf3_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + mf3_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + mf3_pkg::QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - mf3_pkg::QCNT_W'(1);
        end
    end

endmodule

[hw/rtl/mf3_back.sv]
// mf3_back: row store, sliding 3x3 window and median network of the filter
// depends on mf3_pkg and mf3_if
`timescale 1ns / 1ps

module mf3_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mf3_pkg::job_t  q_head,
    output logic           q_pop,
    mf3_res_if.source      filtered
);

    localparam int PW = mf3_pkg::PIX_W;

    typedef struct packed
    {
        logic [PW-1:0] lo;
        logic [PW-1:0] md;
        logic [PW-1:0] hi;
        logic [PW-1:0] raw;
    } col_t;

    logic [PW-1:0] store [mf3_pkg::STORE_DEPTH];

    // read stage
    logic          v1_reg;
    logic          emit1_reg;
    logic          border1_reg;
    logic          last1_reg;
    logic [PW-1:0] pix1_reg;
    logic [PW-1:0] up1_reg;
    logic [PW-1:0] mid1_reg;

    // window stage
    logic          v2_reg;
    logic          emit2_reg;
    logic          border2_reg;
    logic          last2_reg;
    col_t          win_reg [3];
    col_t          new_col;

    // reduce stage
    logic          v3_reg;
    logic          border3_reg;
    logic          last3_reg;
    logic [PW-1:0] lo_max_reg;
    logic [PW-1:0] md_med_reg;
    logic [PW-1:0] hi_min_reg;
    logic [PW-1:0] raw3_reg;

    // output register
    logic          v4_reg;
    logic          border4_reg;
    logic          last4_reg;
    logic [PW-1:0] pix4_reg;

    logic          adv1;
    logic          adv2;
    logic          adv3;
    logic          adv4;

    function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PW-1:0] max2(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PW-1:0] med3
    (
        input logic [PW-1:0] a,
        input logic [PW-1:0] b,
        input logic [PW-1:0] c
    );
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    assign adv4  = !v4_reg || filtered.ready;
    assign adv3  = !v3_reg || adv4;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;
    assign q_pop = q_valid && adv1;

    // store write and registered reads of the two rows above the new pixel
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_head.wr_en)
                store[q_head.wr_addr] <= q_head.pixel;
            up1_reg     <= store[q_head.up_addr];
            mid1_reg    <= store[q_head.mid_addr];
            pix1_reg    <= q_head.pixel;
            emit1_reg   <= q_head.emit;
            border1_reg <= q_head.border;
            last1_reg   <= q_head.last;
        end
    end

    // incoming column sorted once on entry; raw centre kept for border beats
    always_comb
    begin
        new_col.lo  = min2(min2(up1_reg, mid1_reg), pix1_reg);
        new_col.hi  = max2(max2(up1_reg, mid1_reg), pix1_reg);
        new_col.md  = med3(up1_reg, mid1_reg, pix1_reg);
        new_col.raw = mid1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            win_reg[0]  <= win_reg[1];
            win_reg[1]  <= win_reg[2];
            win_reg[2]  <= new_col;
            emit2_reg   <= emit1_reg;
            border2_reg <= border1_reg;
            last2_reg   <= last1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            lo_max_reg  <= max2(max2(win_reg[0].lo, win_reg[1].lo), win_reg[2].lo);
            md_med_reg  <= med3(win_reg[0].md, win_reg[1].md, win_reg[2].md);
            hi_min_reg  <= min2(min2(win_reg[0].hi, win_reg[1].hi), win_reg[2].hi);
            raw3_reg    <= win_reg[1].raw;
            border3_reg <= border2_reg;
            last3_reg   <= last2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            pix4_reg    <= border3_reg ? raw3_reg : med3(lo_max_reg, md_med_reg, hi_min_reg);
            border4_reg <= border3_reg;
            last4_reg   <= last3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= q_valid;
            if (adv2)
                v2_reg <= v1_reg;
            // only emitting jobs carry on past the window
            if (adv3)
                v3_reg <= v2_reg && emit2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    assign filtered.valid      = v4_reg;
    assign filtered.pixel_out  = pix4_reg;
    assign filtered.is_border  = border4_reg;
    assign filtered.frame_last = last4_reg;

endmodule

[hw/rtl/median_filter_3x3.sv]
// median_filter_3x3: top level of the streaming 3x3 median filter
// depends on mf3_pkg, mf3_if, mf3_front, mf3_queue and mf3_back
`timescale 1ns / 1ps

// Usage
//   pixels   : command 0 pushes pixel_in, command 1 drains one pending output.
//   filtered : pixel_out with is_border and frame_last, one beat per result.
//   regs     : index 0 frame_width (clamped to 3..64), index 1 frame_height
//              (clamped to 3..1024); always ready, a write to either restarts
//              the frame, other indices are ignored.
//              Write only while no result is outstanding.
//   Pixels go in raster order. The result for pixel k comes with the push of
//   pixel k + width + 1; the last width + 1 results need one drain each.
//   Pushes after the frame's last pixel, and drains before it, give no result.
//   Pipeline: a result beat is registered after the beat that causes it through
//   queue write, store read, window shift, min/max reduce and final median.
//   Throughput: one beat per cycle while filtered is not held off; set by the
//   registered store read and the window shift done once per beat.
//   Stall: when filtered is held off, the pipeline holds and the two-entry job
//   queue fills; pixels.ready then falls until results are taken.
//   Reset: 5x5 frame, all positions cleared, pipeline empty. Row store contents
//   are undefined but never used before the current frame writes them.
module median_filter_3x3
(
    input  logic      clk,
    input  logic      rst_n,
    mf3_pix_if.sink   pixels,
    mf3_res_if.source filtered,
    mf3_cfg_if.sink   regs
);

    logic           q_full;
    logic           enq;
    logic           q_valid;
    logic           q_pop;
    mf3_pkg::job_t  enq_job;
    mf3_pkg::job_t  q_head;

    mf3_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .regs    (regs),
        .q_full  (q_full),
        .enq     (enq),
        .enq_job (enq_job)
    );

    mf3_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (enq),
        .push_job (enq_job),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head),
        .pop      (q_pop)
    );

    mf3_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .filtered (filtered)
    );

endmodule

[hw/rtl/mf3_checker.sv]
// mf3_checker: port-level assertions for median_filter_3x3, bound to the top level
// depends on mf3_pkg and median_filter_3x3_assert.svh
`timescale 1ns / 1ps
`include "median_filter_3x3_assert.svh"

module mf3_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [mf3_pkg::PIX_W-1:0]  out_pixel,
    input logic                       out_is_border,
    input logic                       out_frame_last
);

    // a stalled result beat stays put
    `MF3_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel) && $stable(out_is_border) && $stable(out_frame_last))

    // the last pixel of a frame, its lower-right corner, is a border pixel
    `MF3_ASSERT_IMP(a_last_is_border, clk, rst_n, out_valid && out_frame_last, out_is_border)

    // input back-pressure only follows an output stall
    `MF3_ASSERT_IMP(a_ready_after_stall, clk, rst_n, !in_ready, $past(out_valid && !out_ready))

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (pixels.ready),
    .out_valid      (filtered.valid),
    .out_ready      (filtered.ready),
    .out_pixel      (filtered.pixel_out),
    .out_is_border  (filtered.is_border),
    .out_frame_last (filtered.frame_last)
);

[tb/sv/tb_median_filter_3x3.sv]
// tb_median_filter_3x3: self-checking testbench of the streaming 3x3 median filter
// needs mf3_pkg, the mf3_if channel interfaces and the median_filter_3x3 rtl
`timescale 1ns / 1ps

module tb_median_filter_3x3;

    localparam int WINDOW        = 9;
    localparam int NUM_REGS      = 2;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES   = 20;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 450;
    localparam int TALL_ROWS     = 8;

    typedef enum int
    {
        IDLE_SLOW_SOURCE,
        IDLE_SLOW_SINK,
        IDLE_NONE
    } idle_mode_t;

    typedef struct packed
    {
        mf3_pkg::cmd_t             command;
        logic [mf3_pkg::PIX_W-1:0] pixel;
    } pix_beat_t;

    typedef struct packed
    {
        logic [mf3_pkg::PIX_W-1:0] pixel;
        logic                      border;
        logic                      last;
    } filt_pix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mf3_pix_if pix_if ();
    mf3_res_if res_if ();
    mf3_cfg_if cfg_if ();

    median_filter_3x3 u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pix_if),
        .filtered (res_if),
        .regs     (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus and expectations
    pix_beat_t pixel_queue [$];
    filt_pix_t expected_pixels [$];

    int unsigned sender_idle_pct = 0;
    int unsigned recv_idle_pct   = 0;
    bit          stall_request   = 1'b0;
    bit          stall_done      = 1'b0;
    int unsigned hold_cycles     = 0;
    int unsigned error_count     = 0;
    int unsigned quiet_cycles    = 0;

    // filter state as the block should hold it
    logic [mf3_pkg::PIX_W-1:0] row_store [0:mf3_pkg::STORE_DEPTH-1];
    int unsigned               in_row, in_col, out_row, out_col;
    bit                        frame_in_done;
    logic [mf3_pkg::FW_W-1:0]  frame_width_reg;
    logic [mf3_pkg::FH_W-1:0]  frame_height_reg;

    function automatic int unsigned active_width();
        int unsigned w;
        w = frame_width_reg;
        if (w < 3)
            w = 3;
        if (w > mf3_pkg::MAX_WIDTH)
            w = mf3_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = frame_height_reg;
        if (h < 3)
            h = 3;
        if (h > mf3_pkg::MAX_HEIGHT)
            h = mf3_pkg::MAX_HEIGHT;
        return h;
    endfunction

    function automatic void restart_frame();
        in_row        = 0;
        in_col        = 0;
        out_row       = 0;
        out_col       = 0;
        frame_in_done = 1'b0;
    endfunction

    function automatic void reset_filter_state();
        foreach (row_store[i])
            row_store[i] = '0;
        frame_width_reg  = mf3_pkg::FW_W'(5);
        frame_height_reg = mf3_pkg::FH_W'(5);
        restart_frame();
    endfunction

    function automatic logic [mf3_pkg::PIX_W-1:0] store_at(int unsigned r, int unsigned c);
        return row_store[(r % 3) * mf3_pkg::MAX_WIDTH + c];
    endfunction

    function automatic logic [mf3_pkg::PIX_W-1:0] median_at(int unsigned r, int unsigned c);
        logic [mf3_pkg::PIX_W-1:0] win [WINDOW];
        logic [mf3_pkg::PIX_W-1:0] t;
        int                        k, dr, dc, i, j;
        k = 0;
        for (dr = 0; dr < 3; dr++)
            for (dc = 0; dc < 3; dc++)
            begin
                win[k] = store_at(r - 1 + dr, c - 1 + dc);
                k++;
            end
        for (i = 0; i < WINDOW - 1; i++)
            for (j = 0; j < WINDOW - 1 - i; j++)
                if (win[j] > win[j + 1])
                begin
                    t          = win[j];
                    win[j]     = win[j + 1];
                    win[j + 1] = t;
                end
        return win[WINDOW / 2];
    endfunction

    function automatic void emit_pixel(int unsigned w, int unsigned h);
        filt_pix_t   res;
        int unsigned r, c;
        r          = out_row;
        c          = out_col;
        res.border = (r == 0) || (c == 0) || (r == h - 1) || (c == w - 1);
        res.last   = (r == h - 1) && (c == w - 1);
        res.pixel  = res.border ? store_at(r, c) : median_at(r, c);
        expected_pixels.push_back(res);
        if (res.last)
            restart_frame();
        else if (c + 1 >= w)
        begin
            out_col = 0;
            out_row = r + 1;
        end
        else
            out_col = c + 1;
    endfunction

    function automatic void filter_step(mf3_pkg::cmd_t command,
                                        logic [mf3_pkg::PIX_W-1:0] pixel);
        int unsigned w, h, r, c;
        bit          window_full;
        w = active_width();
        h = active_height();
        if (command == mf3_pkg::CMD_DRAIN)
        begin
            if (frame_in_done)
                emit_pixel(w, h);
            return;
        end
        // frame fully pushed: further pixels are dropped until it is drained
        if (frame_in_done)
            return;
        r           = in_row;
        c           = in_col;
        window_full = (r >= 2) || (r == 1 && c >= 1);
        row_store[(r % 3) * mf3_pkg::MAX_WIDTH + c] = pixel;
        if (c + 1 >= w)
        begin
            in_col = 0;
            if (r + 1 >= h)
                frame_in_done = 1'b1;
            else
                in_row = r + 1;
        end
        else
            in_col = c + 1;
        if (window_full)
            emit_pixel(w, h);
    endfunction

    function automatic void apply_reg_write(logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                                            logic [mf3_pkg::CFG_DATA_W-1:0] value);
        if (idx == mf3_pkg::CFG_FRAME_WIDTH)
        begin
            frame_width_reg = value[mf3_pkg::FW_W-1:0];
            restart_frame();
        end
        else if (idx == mf3_pkg::CFG_FRAME_HEIGHT)
        begin
            frame_height_reg = value[mf3_pkg::FH_W-1:0];
            restart_frame();
        end
    endfunction

    // pixel driver
    pix_beat_t next_beat;
    bit        offer_open;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_if.valid    <= 1'b0;
            pix_if.command  <= mf3_pkg::CMD_PUSH;
            pix_if.pixel_in <= '0;
        end
        else
        begin
            offer_open = !pix_if.valid || pix_if.ready;
            if (pix_if.valid && pix_if.ready)
                filter_step(mf3_pkg::cmd_t'(pix_if.command), pix_if.pixel_in);
            if (offer_open)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_beat = pixel_queue.pop_front();
                    pix_if.valid    <= 1'b1;
                    pix_if.command  <= next_beat.command;
                    pix_if.pixel_in <= next_beat.pixel;
                end
                else
                    pix_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    filt_pix_t got_exp;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected beat: pixel_out %0d is_border %0b frame_last %0b",
                           res_if.pixel_out, res_if.is_border, res_if.frame_last);
                    error_count++;
                end
                else
                begin
                    got_exp = expected_pixels.pop_front();
                    if (res_if.pixel_out !== got_exp.pixel)
                    begin
                        $error("pixel_out: expected %0d, got %0d",
                               got_exp.pixel, res_if.pixel_out);
                        error_count++;
                    end
                    if (res_if.is_border !== got_exp.border)
                    begin
                        $error("is_border: expected %0b, got %0b",
                               got_exp.border, res_if.is_border);
                        error_count++;
                    end
                    if (res_if.frame_last !== got_exp.last)
                    begin
                        $error("frame_last: expected %0b, got %0b",
                               got_exp.last, res_if.frame_last);
                        error_count++;
                    end
                end
            end
            // one long hold-off so the job queue fills and input backs up
            if (stall_request && !stall_done)
            begin
                hold_cycles = HOLD_CYCLES;
                stall_done  = 1'b1;
            end
            if (hold_cycles != 0)
            begin
                hold_cycles--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("median_filter_3x3 test failed");
            $finish;
        end
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_SLOW_SOURCE:
            begin
                sender_idle_pct = 36;
                recv_idle_pct   = 71;
            end
            IDLE_SLOW_SINK:
            begin
                sender_idle_pct = 71;
                recv_idle_pct   = 36;
            end
            default:
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
        endcase
    endtask

    task automatic write_reg(logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                             logic [mf3_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        apply_reg_write(idx, value);
        @(posedge clk);
    endtask

    task automatic write_unused_reg();
        write_reg(mf3_pkg::CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** mf3_pkg::CFG_IDX_W - 1)),
                  mf3_pkg::CFG_DATA_W'($urandom));
    endtask

    // all beats sent, all results back, then let the pipeline empty
    task automatic settle_pipeline();
        while (pixel_queue.size() != 0 || pix_if.valid)
            @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_beat(mf3_pkg::cmd_t command,
                                       logic [mf3_pkg::PIX_W-1:0] pixel);
        pix_beat_t b;
        b.command = command;
        b.pixel   = pixel;
        pixel_queue.push_back(b);
    endfunction

    function automatic logic [mf3_pkg::PIX_W-1:0] rand_pixel();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? mf3_pkg::PIX_W'(255) : mf3_pkg::PIX_W'(0);
        return mf3_pkg::PIX_W'($urandom_range(255));
    endfunction

    // whole frame then its tail of drains; noisy frames add beats that are dropped
    function automatic void queue_frame(int unsigned w, int unsigned h, bit noisy);
        int unsigned i;
        for (i = 0; i < w * h; i++)
        begin
            if (noisy && $urandom_range(9) == 0)
                queue_beat(mf3_pkg::CMD_DRAIN, rand_pixel());
            queue_beat(mf3_pkg::CMD_PUSH, rand_pixel());
        end
        if (noisy && $urandom_range(1) == 0)
            queue_beat(mf3_pkg::CMD_PUSH, rand_pixel());
        for (i = 0; i < w + 1; i++)
        begin
            queue_beat(mf3_pkg::CMD_DRAIN, rand_pixel());
            if (noisy && $urandom_range(7) == 0)
                queue_beat(mf3_pkg::CMD_PUSH, rand_pixel());
        end
        if (noisy && $urandom_range(1) == 0)
            queue_beat(mf3_pkg::CMD_DRAIN, rand_pixel());
    endfunction

    function automatic logic [mf3_pkg::FW_W-1:0] pick_width();
        case ($urandom_range(19))
            0:       return mf3_pkg::FW_W'(mf3_pkg::MAX_WIDTH);
            1:       return mf3_pkg::FW_W'($urandom_range(mf3_pkg::MAX_WIDTH + 1,
                                                          2 ** mf3_pkg::FW_W - 1));
            2:       return mf3_pkg::FW_W'($urandom_range(2));
            default: return mf3_pkg::FW_W'($urandom_range(3, 10));
        endcase
    endfunction

    function automatic logic [mf3_pkg::FH_W-1:0] pick_height();
        if ($urandom_range(5) == 0)
            return mf3_pkg::FH_W'($urandom_range(2));
        return mf3_pkg::FH_W'($urandom_range(3, 8));
    endfunction

    int unsigned               item_budget;
    int unsigned               phase_no;
    int unsigned               fw, fh, k;
    logic [mf3_pkg::PIX_W-1:0] corner_pix [9];

    initial
    begin
        pix_if.valid    = 1'b0;
        pix_if.command  = mf3_pkg::CMD_PUSH;
        pix_if.pixel_in = '0;
        res_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        reset_filter_state();
        set_idling(IDLE_SLOW_SOURCE);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame is 5x5: drain with nothing pending, partial frame, early drain
        queue_beat(mf3_pkg::CMD_DRAIN, mf3_pkg::PIX_W'(0));
        for (k = 0; k < 7; k++)
            queue_beat(mf3_pkg::CMD_PUSH, (k % 2) ? mf3_pkg::PIX_W'(255) : mf3_pkg::PIX_W'(0));
        queue_beat(mf3_pkg::CMD_DRAIN, mf3_pkg::PIX_W'(255));
        settle_pipeline();

        // under-range sizes clamp to 3x3, upper data bits of the width are dropped
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, mf3_pkg::CFG_DATA_W'(11'h780));
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, mf3_pkg::CFG_DATA_W'(1));
        corner_pix = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd0};
        for (k = 0; k < 4; k++)
            queue_beat(mf3_pkg::CMD_PUSH, corner_pix[k]);
        settle_pipeline();
        // write to an unused index mid-frame must not restart it
        write_unused_reg();
        queue_beat(mf3_pkg::CMD_PUSH, corner_pix[4]);
        queue_beat(mf3_pkg::CMD_DRAIN, mf3_pkg::PIX_W'(0));
        for (k = 5; k < 9; k++)
            queue_beat(mf3_pkg::CMD_PUSH, corner_pix[k]);
        queue_beat(mf3_pkg::CMD_PUSH, mf3_pkg::PIX_W'(77));
        for (k = 0; k < 5; k++)
            queue_beat(mf3_pkg::CMD_DRAIN, mf3_pkg::PIX_W'(0));
        settle_pipeline();

        item_budget = 0;
        phase_no    = 0;
        while (item_budget < RANDOM_ITEMS)
        begin
            set_idling(idle_mode_t'(phase_no % 3));
            case ($urandom_range(2))
                0: write_reg(mf3_pkg::CFG_FRAME_WIDTH,
                             {mf3_pkg::CFG_DATA_W'($urandom) >> mf3_pkg::FW_W << mf3_pkg::FW_W}
                             | pick_width());
                1: write_reg(mf3_pkg::CFG_FRAME_HEIGHT, mf3_pkg::CFG_DATA_W'(pick_height()));
                default:
                begin
                    write_reg(mf3_pkg::CFG_FRAME_WIDTH,
                              {mf3_pkg::CFG_DATA_W'($urandom) >> mf3_pkg::FW_W << mf3_pkg::FW_W}
                              | pick_width());
                    write_reg(mf3_pkg::CFG_FRAME_HEIGHT, mf3_pkg::CFG_DATA_W'(pick_height()));
                end
            endcase
            // keep wide frames short
            if (active_width() > 16 && active_height() > 4)
                write_reg(mf3_pkg::CFG_FRAME_HEIGHT, mf3_pkg::CFG_DATA_W'($urandom_range(4)));
            if ($urandom_range(3) == 0)
                write_unused_reg();
            fw = active_width();
            fh = active_height();
            if ($urandom_range(7) == 0)
            begin
                // abandoned by the next register write
                for (k = $urandom_range(1, fw * fh - 1); k != 0; k--)
                    queue_beat(mf3_pkg::CMD_PUSH, rand_pixel());
                item_budget += fw * fh / 2;
            end
            else
            begin
                queue_frame(fw, fh, $urandom_range(3) == 0);
                item_budget += fw * fh + fw + 1;
            end
            settle_pipeline();
            phase_no++;
        end

        // full-width frame with the sender always offering while the sink holds off
        set_idling(IDLE_NONE);
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, mf3_pkg::CFG_DATA_W'(mf3_pkg::MAX_WIDTH));
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, mf3_pkg::CFG_DATA_W'(3));
        stall_request = 1'b1;
        queue_frame(mf3_pkg::MAX_WIDTH, 3, 1'b0);
        settle_pipeline();

        // tall frame: height data all ones clamps to the maximum; only its top rows go in
        set_idling(IDLE_SLOW_SOURCE);
        write_reg(mf3_pkg::CFG_FRAME_WIDTH, mf3_pkg::CFG_DATA_W'(11'h783));
        write_reg(mf3_pkg::CFG_FRAME_HEIGHT, {mf3_pkg::CFG_DATA_W{1'b1}});
        for (k = 0; k < 3 * TALL_ROWS; k++)
            queue_beat(mf3_pkg::CMD_PUSH, rand_pixel());
        queue_beat(mf3_pkg::CMD_DRAIN, rand_pixel());
        settle_pipeline();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("median_filter_3x3 test passed");
        else
            $display("median_filter_3x3 test failed");
        $finish;
    end

endmodule
